// ----- design/tspt_pkg.sv -----
package tspt_pkg;

	typedef struct packed {
		logic               op;
		logic [5:0]         start_position;
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_z;
	} in_beat_t;

	typedef struct packed {
		logic [5:0] position;
		logic       moved;
	} out_beat_t;

	localparam logic OP_START  = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	// Angles in Q9.16 degrees.
	localparam int ANG_W = 25;
	localparam logic signed [27:0] FULL_TURN = 28'sd23592960;
	localparam logic signed [27:0] HALF_TURN = 28'sd11796480;
	localparam logic signed [27:0] DEG_ONE   = 28'sd65536;
	localparam int ATAN_LEN = 24;

	// Work carried from the front to the back.
	typedef struct packed {
		logic               is_start;
		logic [5:0]         pos;
		logic               accept;   // sample passed the flat and size checks
		logic signed [16:0] vx;
		logic signed [16:0] vy;
		logic [16:0]        s;
	} job_t;

	function automatic logic signed [27:0] atan_entry(input logic [4:0] i);
		logic signed [27:0] r;
		begin
			case (i)
				5'd0:  r = 28'sd2949120;
				5'd1:  r = 28'sd1740967;
				5'd2:  r = 28'sd919879;
				5'd3:  r = 28'sd466945;
				5'd4:  r = 28'sd234379;
				5'd5:  r = 28'sd117304;
				5'd6:  r = 28'sd58666;
				5'd7:  r = 28'sd29335;
				5'd8:  r = 28'sd14668;
				5'd9:  r = 28'sd7334;
				5'd10: r = 28'sd3667;
				5'd11: r = 28'sd1833;
				5'd12: r = 28'sd917;
				5'd13: r = 28'sd458;
				5'd14: r = 28'sd229;
				5'd15: r = 28'sd115;
				5'd16: r = 28'sd57;
				5'd17: r = 28'sd29;
				5'd18: r = 28'sd14;
				5'd19: r = 28'sd7;
				5'd20: r = 28'sd4;
				5'd21: r = 28'sd2;
				5'd22: r = 28'sd1;
				default: r = 28'sd0;
			endcase
			return r;
		end
	endfunction

endpackage

// ----- design/tspt_front.sv -----
module tspt_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [14:0]      cfg_data,
	input  logic             in_valid,
	output logic             in_ready,
	input  tspt_pkg::in_beat_t in_data,
	output logic             job_valid,
	input  logic             job_ready,
	output tspt_pkg::job_t   job_data
);
	import tspt_pkg::*;

	logic [14:0] one_g_q;
	logic [15:0] filt_z_q;
	logic [15:0] az;
	logic [15:0] ax;
	logic [15:0] ay;
	logic [16:0] s;
	logic [14:0] thr;
	logic [15:0] filt_next;
	logic [17:0] thr_mul;
	logic [18:0] az_mul;

	// Two-entry queue between the front and the back.
	job_t        q_mem_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  cnt_q;
	logic        push;
	logic        pop;
	job_t        job_new;

	assign az = in_data.accel_z[15] ? 16'(-in_data.accel_z) : 16'(in_data.accel_z);
	assign ax = in_data.accel_x[15] ? 16'(-in_data.accel_x) : 16'(in_data.accel_x);
	assign ay = in_data.accel_y[15] ? 16'(-in_data.accel_y) : 16'(in_data.accel_y);
	assign s  = {1'b0, ax} + {1'b0, ay};
	assign thr_mul = {3'b000, one_g_q} * 18'd7;
	assign thr = thr_mul[17:3];
	assign az_mul = {3'b000, az} * 19'd7;
	assign filt_next = {3'b000, filt_z_q[15:3]} + az_mul[18:3];

	always_comb begin
		job_new.is_start = (in_data.op == OP_START);
		job_new.pos      = in_data.start_position;
		job_new.accept   = ({1'b0, az} <= {2'b00, thr}) && (filt_next <= {1'b0, thr})
			&& (s >= 17'd5);
		job_new.vx       = -17'(in_data.accel_x);
		job_new.vy       = -17'(in_data.accel_y);
		job_new.s        = s;
	end

	assign in_ready  = (cnt_q != 2'd2);
	assign push      = in_valid && in_ready;
	assign job_valid = (cnt_q != 2'd0);
	assign pop       = job_valid && job_ready;
	assign job_data  = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			one_g_q  <= 15'd1024;
			filt_z_q <= 16'd1024;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (cfg_we) begin
				one_g_q <= cfg_data;
			end
			if (push && in_data.op == OP_SAMPLE) begin
				filt_z_q <= filt_next;
			end
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= job_new;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue count out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2 && !pop) |=> cnt_q == 2'd2)
		else $error("full queue lost an entry");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("empty queue pointers disagree");

endmodule

// ----- design/tspt_back.sv -----
module tspt_back #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               job_valid,
	output logic               job_ready,
	input  tspt_pkg::job_t     job_data,
	output logic               out_valid,
	input  logic               out_ready,
	output tspt_pkg::out_beat_t out_data
);
	import tspt_pkg::*;

	localparam int STEP_W = $clog2(ATAN_LEN + 1);
	// 2^37 * 32 / 125 rounded up, split into two 18-bit halves.
	localparam logic [17:0] DIV_K_HI = 18'd134217;
	localparam logic [17:0] DIV_K_LO = 18'd190841;
	// 2^23 / 360 and 2^11 / 6, rounded up.
	localparam logic [14:0] TURN_K   = 15'd23302;
	localparam logic [18:0] SIXTH_K  = 19'd342;

	typedef enum logic [11:0] {
		ST_IDLE  = 12'b000000000001,
		ST_ROT   = 12'b000000000010,
		ST_DELTA = 12'b000000000100,
		ST_MUL1  = 12'b000000001000,
		ST_MUL2  = 12'b000000010000,
		ST_ADV   = 12'b000000100000,
		ST_RECIP = 12'b000001000000,
		ST_QUOT  = 12'b000010000000,
		ST_SUM   = 12'b000100000000,
		ST_WRAP  = 12'b001000000000,
		ST_POS   = 12'b010000000000,
		ST_DONE  = 12'b100000000000
	} st_t;

	st_t                 st_q;
	logic [STEP_W-1:0]   step_q;
	logic signed [27:0]  cx_q;
	logic signed [27:0]  cy_q;
	logic signed [27:0]  cz_q;
	logic [ANG_W-1:0]    angle_q;
	logic [5:0]          pos_q;
	logic signed [31:0]  vel_q;
	logic signed [27:0]  d_q;
	logic [16:0]         s_q;
	logic signed [45:0]  ds_q;
	logic signed [47:0]  v_q;
	logic [49:0]         prod_hi_q;
	logic [49:0]         prod_lo_q;
	logic signed [31:0]  adv_q;
	logic signed [31:0]  sum_q;
	logic [6:0]          turn_q;
	logic                out_full_q;
	out_beat_t           out_q;

	logic signed [27:0]  dx;
	logic signed [27:0]  dy;
	logic signed [27:0]  atv;
	logic signed [27:0]  ang_w;
	logic signed [27:0]  d_raw;
	logic signed [27:0]  d_fix;
	logic signed [27:0]  d_abs;
	logic signed [47:0]  v_sum;
	logic signed [31:0]  v_sat;
	logic [31:0]         v_mag;
	logic [67:0]         quot_w;
	logic [29:0]         adv_mag;
	logic signed [31:0]  adv_w;
	logic [14:0]         deg_w;
	logic [29:0]         turn_mul;
	logic [8:0]          deg_mod;
	logic [9:0]          t_deg;
	logic [8:0]          t_mod;
	logic [9:0]          p_num;
	logic [18:0]         p_mul;
	logic [7:0]          p_w;
	logic [5:0]          p_sat;
	logic [9:0]          start_deg;
	logic [8:0]          start_mod;
	logic [5:0]          start_pos;
	logic                out_set;

	assign dx  = cy_q >>> step_q;
	assign dy  = cx_q >>> step_q;
	assign atv = atan_entry(5'(step_q));

	assign ang_w = cz_q[27] ? cz_q + FULL_TURN : cz_q;
	assign d_raw = ang_w - {3'b000, angle_q};
	assign d_fix = (d_raw > HALF_TURN) ? d_raw - FULL_TURN
		: ((d_raw < -HALF_TURN) ? d_raw + FULL_TURN : d_raw);
	assign d_abs = d_fix[27] ? -d_fix : d_fix;

	// v = floor(v/4) + floor(d*s*3/1024), saturated, then held to |v| >= 2.0.
	assign v_sum = 48'(vel_q >>> 2) + 48'((ds_q * 46'sd3) >>> 10);
	always_comb begin
		if (v_q > 48'sd2147483647) begin
			v_sat = 32'sh7fffffff;
		end else if (v_q < -48'sd2147483648) begin
			v_sat = 32'sh80000000;
		end else begin
			v_sat = 32'(v_q);
		end
		if (v_sat < 32'sd512 && v_sat > -32'sd512) begin
			v_sat = v_sat[31] ? -32'sd512 : 32'sd512;
		end
	end

	// Advance by (v*256)/1000 toward zero: |v|*32/125 by reciprocal, then the sign.
	assign v_mag   = vel_q[31] ? 32'(-vel_q) : 32'(vel_q);
	assign quot_w  = {prod_hi_q, 18'd0} + {18'd0, prod_lo_q};
	assign adv_mag = quot_w[66:37];
	assign adv_w   = vel_q[31] ? -signed'({2'b00, adv_mag}) : signed'({2'b00, adv_mag});

	// Whole degrees of the sum, offset by 24 turns so the value is never negative.
	assign deg_w    = 15'((sum_q >>> 16) + 32'sd8640);
	assign turn_mul = 30'(deg_w) * 30'(TURN_K);
	assign deg_mod  = 9'(deg_w - 15'(turn_q) * 15'd360);

	assign t_deg = 10'((26'd29491200 - {1'b0, angle_q}) >> 16);
	assign t_mod = (t_deg >= 10'd360) ? 9'(t_deg - 10'd360) : 9'(t_deg);
	assign p_num = 10'(t_mod) + 10'd3;
	assign p_mul = 19'(p_num) * SIXTH_K;
	assign p_w   = p_mul[18:11];
	assign p_sat = (p_w > 8'd59) ? 6'd59 : 6'(p_w);

	assign start_deg = 10'd450 - 10'(job_data.pos) * 10'd6;
	assign start_mod = (start_deg >= 10'd360) ? 9'(start_deg - 10'd360) : 9'(start_deg);
	assign start_pos = (job_data.pos > 6'd59) ? 6'd59 : job_data.pos;

	assign job_ready = (st_q == ST_IDLE) && (!out_full_q || out_ready);
	assign out_valid = out_full_q;
	assign out_data  = out_q;

	assign out_set = ((st_q == ST_IDLE) && job_valid && job_ready
		&& (job_data.is_start || !job_data.accept))
		|| ((st_q == ST_DELTA) && (d_abs < DEG_ONE))
		|| (st_q == ST_DONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			step_q     <= '0;
			out_full_q <= 1'b0;
			out_q      <= '0;
			angle_q    <= '0;
			pos_q      <= '0;
			vel_q      <= '0;
		end else begin
			out_full_q <= out_set || (out_full_q && !out_ready);
			case (st_q)
				ST_IDLE: begin
					if (job_valid && job_ready) begin
						if (job_data.is_start) begin
							angle_q          <= ANG_W'({start_mod, 16'd0});
							pos_q            <= start_pos;
							out_q.position   <= start_pos;
							out_q.moved      <= 1'b0;
						end else if (!job_data.accept) begin
							out_q.position   <= pos_q;
							out_q.moved      <= 1'b0;
						end else begin
							s_q    <= job_data.s;
							step_q <= '0;
							if (job_data.vx[16]) begin
								if (!job_data.vy[16]) begin
									cx_q <= 28'(job_data.vy) <<< 8;
									cy_q <= -(28'(job_data.vx) <<< 8);
									cz_q <= 28'sd5898240;
								end else begin
									cx_q <= -(28'(job_data.vy) <<< 8);
									cy_q <= 28'(job_data.vx) <<< 8;
									cz_q <= -28'sd5898240;
								end
							end else begin
								cx_q <= 28'(job_data.vx) <<< 8;
								cy_q <= 28'(job_data.vy) <<< 8;
								cz_q <= '0;
							end
							st_q <= ST_ROT;
						end
					end
				end
				ST_ROT: begin
					if (cy_q > 28'sd0) begin
						cx_q <= cx_q + dx;
						cy_q <= cy_q - dy;
						cz_q <= cz_q + atv;
					end else begin
						cx_q <= cx_q - dx;
						cy_q <= cy_q + dy;
						cz_q <= cz_q - atv;
					end
					if (step_q == STEP_W'(CORDIC_STEPS - 1)) begin
						st_q <= ST_DELTA;
					end
					step_q <= step_q + 1'b1;
				end
				ST_DELTA: begin
					d_q <= d_fix;
					if (d_abs < DEG_ONE) begin
						vel_q          <= '0;
						out_q.position <= pos_q;
						out_q.moved    <= 1'b0;
						st_q           <= ST_IDLE;
					end else begin
						st_q <= ST_MUL1;
					end
				end
				ST_MUL1: begin
					ds_q <= 46'(d_q) * 46'(signed'({1'b0, s_q}));
					st_q <= ST_MUL2;
				end
				ST_MUL2: begin
					v_q  <= v_sum;
					st_q <= ST_ADV;
				end
				ST_ADV: begin
					vel_q <= v_sat;
					st_q  <= ST_RECIP;
				end
				ST_RECIP: begin
					prod_hi_q <= 50'(v_mag) * 50'(DIV_K_HI);
					prod_lo_q <= 50'(v_mag) * 50'(DIV_K_LO);
					st_q      <= ST_QUOT;
				end
				ST_QUOT: begin
					adv_q <= adv_w;
					st_q  <= ST_SUM;
				end
				ST_SUM: begin
					sum_q <= signed'({7'd0, angle_q}) + adv_q;
					st_q  <= ST_WRAP;
				end
				ST_WRAP: begin
					turn_q <= turn_mul[29:23];
					st_q   <= ST_POS;
				end
				ST_POS: begin
					angle_q <= {deg_mod, sum_q[15:0]};
					st_q    <= ST_DONE;
				end
				ST_DONE: begin
					pos_q          <= p_sat;
					out_q.position <= p_sat;
					out_q.moved    <= 1'b1;
					st_q           <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) $onehot(st_q))
		else $error("state register not one-hot");
	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_ROT) |-> step_q < STEP_W'(CORDIC_STEPS))
		else $error("CORDIC step out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != ST_IDLE) |-> !job_ready)
		else $error("job taken while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
		else $error("waiting result changed");

endmodule

// ----- design/tilt_spin_position_tracker_unit.sv -----
// Channel  Direction  Payload     Handshake
// in       input      in_beat_t   in_valid / in_ready
// out      output     out_beat_t  out_valid / out_ready
// cfg      input      15 bits     cfg_we, no wait
//
// A start or rejected sample is registered in the queue and then in the output register.
// An accepted sample runs the serial CORDIC loop, then DELTA, MUL1, MUL2, ADV, RECIP,
// QUOT, SUM, WRAP, POS and DONE states; one whose angle barely moves ends at DELTA.
// Reset clears control, angle, position and velocity; one_g_level and filtered |z| reset to 1024.
// A two-beat queue lets the front take up to two beats while the back is busy,
// and a stalled output holds the back without losing a result.
module tilt_spin_position_tracker_unit #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [14:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  tspt_pkg::in_beat_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output tspt_pkg::out_beat_t out_data
);
	import tspt_pkg::*;

	job_t job_data;
	logic job_valid;
	logic job_ready;

	// The front filters |z|, checks the thresholds and queues the work.
	tspt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job_data  (job_data)
	);

	// The back runs the CORDIC and the velocity and angle update.
	tspt_back #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job_data  (job_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
